// ===== sv/ckre_pkg.sv =====
// shared types and constants for the color key run extractor
package ckre_pkg;

   localparam int COORD_BITS    = 12;
   localparam int END_BITS      = COORD_BITS + 1;
   localparam int SIZE_BITS     = 13;
   localparam int CHAN_BITS     = 8;
   localparam int COLOR_BITS    = 3 * CHAN_BITS;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_KEY_COLOR    = 2'd0,
      REG_TOLERANCE    = 2'd1,
      REG_IMAGE_WIDTH  = 2'd2,
      REG_IMAGE_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] pixel_red;
      logic [CHAN_BITS-1:0] pixel_green;
      logic [CHAN_BITS-1:0] pixel_blue;
   } pixel_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] span_start_x;
      logic [END_BITS-1:0]   span_end_x;
      logic [COORD_BITS-1:0] span_row;
   } span_type;

   typedef struct packed {
      logic keyed;
   } class_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] key_color;
      logic [COLOR_BITS-1:0] tolerance;
      logic [SIZE_BITS-1:0]  image_width;
      logic [SIZE_BITS-1:0]  image_height;
   } csr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/ckre_front.sv =====
// front end: accepts pixel beats and classifies each as keyed or opaque
module ckre_front
   import ckre_pkg::*;
(
   input  logic             reset,
   input  csr_type          csr,
   input  logic             req_valid,
   input  pixel_type        req_payload,
   output logic             req_stall,
   input  queue_status_type queue_status,
   output logic             push,
   output class_type        push_data
);

   function automatic logic chan_keyed(input logic [CHAN_BITS-1:0] pix,
                                       input logic [CHAN_BITS-1:0] lo,
                                       input logic [CHAN_BITS-1:0] tol);
      logic [CHAN_BITS:0] hi;
      hi = {1'b0, lo} + {1'b0, tol};
      return (pix >= lo) && ({1'b0, pix} <= hi);
   endfunction

   logic keyed;

   always_comb begin
      keyed = chan_keyed(req_payload.pixel_red,
                         csr.key_color[CHAN_BITS-1:0],
                         csr.tolerance[CHAN_BITS-1:0])
           && chan_keyed(req_payload.pixel_green,
                         csr.key_color[2*CHAN_BITS-1:CHAN_BITS],
                         csr.tolerance[2*CHAN_BITS-1:CHAN_BITS])
           && chan_keyed(req_payload.pixel_blue,
                         csr.key_color[3*CHAN_BITS-1:2*CHAN_BITS],
                         csr.tolerance[3*CHAN_BITS-1:2*CHAN_BITS]);
   end

   assign req_stall       = reset || queue_status.full;
   assign push            = req_valid && !req_stall;
   assign push_data.keyed = keyed;

endmodule

// ===== sv/ckre_queue.sv =====
// short queue of classified pixels between front and back
module ckre_queue
   import ckre_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  class_type        push_data,
   input  logic             pop,
   output class_type        head_data,
   output queue_status_type status
);

   class_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/ckre_back.sv =====
// back end: column and row counters, run tracking and span output register
module ckre_back
   import ckre_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  csr_type          csr,
   input  queue_status_type queue_status,
   input  class_type        head_data,
   output logic             pop,
   output logic             rsp_valid,
   output span_type         rsp_payload,
   input  logic             rsp_stall
);

   localparam int EXT_BITS = (END_BITS > SIZE_BITS) ? END_BITS : SIZE_BITS;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  run_active_ff, run_active_in;
   logic [COORD_BITS-1:0] run_start_ff, run_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   span_type              rsp_payload_ff, rsp_payload_in;

   logic [COORD_BITS-1:0] width_m1, height_m1, start_x;
   logic                  last_col;

   function automatic logic [COORD_BITS-1:0] size_m1(input logic [SIZE_BITS-1:0] v);
      logic [EXT_BITS-1:0] ext;
      logic [EXT_BITS-1:0] limit;
      ext   = EXT_BITS'(v);
      limit = EXT_BITS'(1) << COORD_BITS;
      if (v == '0) begin
         return '0;
      end else if (ext > limit) begin
         return '1;
      end else begin
         return COORD_BITS'(ext - EXT_BITS'(1));
      end
   endfunction

   assign width_m1  = size_m1(csr.image_width);
   assign height_m1 = size_m1(csr.image_height);
   assign pop       = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign last_col  = col_ff >= width_m1;
   assign start_x   = run_active_ff ? run_start_ff : col_ff;

   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      run_active_in  = run_active_ff;
      run_start_in   = run_start_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (pop) begin
         if (head_data.keyed) begin
            if (run_active_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.span_start_x = run_start_ff;
               rsp_payload_in.span_end_x   = END_BITS'(col_ff);
               rsp_payload_in.span_row     = row_ff;
               run_active_in               = 1'b0;
            end
         end else begin
            if (!run_active_ff) begin
               run_active_in = 1'b1;
               run_start_in  = col_ff;
            end
            if (last_col) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.span_start_x = start_x;
               rsp_payload_in.span_end_x   = END_BITS'(col_ff) + END_BITS'(1);
               rsp_payload_in.span_row     = row_ff;
            end
         end
         if (last_col) begin
            col_in        = '0;
            row_in        = (row_ff >= height_m1) ? '0 : row_ff + COORD_BITS'(1);
            run_active_in = 1'b0;
         end else begin
            col_in = col_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         run_active_ff <= 1'b0;
         run_start_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         run_active_ff <= run_active_in;
         run_start_ff  <= run_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sv/color_key_run_extractor.sv =====
// top level: csr block, front classifier, queue and span back end
// Takes one pixel beat per clock in raster order and returns one span beat
// (start x, exclusive end x, row) for each run of non-keyed pixels in a row.
// The front compares the pixel against the key range in the accept cycle and
// writes the result into a four-entry queue; the back pops one entry per
// clock, updates the column/row counters and loads the span output register,
// so a span is valid once its closing pixel has gone through the queue and
// span output registers, later while spans back up behind a stalled output.
// Sustained rate is one pixel per clock, set by the back end's single
// counter update per cycle; a stalled span output fills the queue and then
// stalls the pixel input. Registers: key color at 0x0, tolerance at 0x4,
// image width at 0x8, image height at 0xc; write them only while idle.
module color_key_run_extractor
   import ckre_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  pixel_type                req_payload,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output span_type                 rsp_payload,
   input  logic                     rsp_stall,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   csr_type          csr_ff, csr_in;
   csr_index_type    csr_index;
   logic             csr_write;
   queue_status_type queue_status;
   logic             push, pop;
   class_type        push_data, head_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_KEY_COLOR:    csr_in.key_color    = csr_pwdata[COLOR_BITS-1:0];
            REG_TOLERANCE:    csr_in.tolerance    = csr_pwdata[COLOR_BITS-1:0];
            REG_IMAGE_WIDTH:  csr_in.image_width  = csr_pwdata[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT: csr_in.image_height = csr_pwdata[SIZE_BITS-1:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY_COLOR:    csr_prdata = CSR_DATA_BITS'(csr_ff.key_color);
         REG_TOLERANCE:    csr_prdata = CSR_DATA_BITS'(csr_ff.tolerance);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(csr_ff.image_width);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(csr_ff.image_height);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.key_color    <= '0;
         csr_ff.tolerance    <= '0;
         csr_ff.image_width  <= SIZE_BITS'(1);
         csr_ff.image_height <= SIZE_BITS'(1);
      end else begin
         csr_ff <= csr_in;
      end
   end

   ckre_front u_front (
      .reset        (reset),
      .csr          (csr_ff),
      .req_valid    (req_valid),
      .req_payload  (req_payload),
      .req_stall    (req_stall),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   ckre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   ckre_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_ff),
      .queue_status (queue_status),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .rsp_stall    (rsp_stall)
   );

endmodule
